/* src/nstr_pkg.sv */
// ----------------------------------------------------------------------------
// nstr_pkg
// shared types and constants of the name-string transcoder
// ----------------------------------------------------------------------------
package nstr_pkg;

    // status codes of the closing result
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_SURR = 2'd2;

    // one decoded character (or end of string) handed from front to back
    typedef struct packed {
        logic [20:0] cp;       // code point
        logic [2:0]  nbytes;   // utf-8 bytes to emit, 0 to 4
        logic        done;     // closing status result follows
        logic [1:0]  status;   // final status of the string
    } nstr_job_t;

endpackage

/* src/nstr_in_if.sv */
// ----------------------------------------------------------------------------
// nstr_in_if
// source byte channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface nstr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* src/nstr_out_if.sv */
// ----------------------------------------------------------------------------
// nstr_out_if
// utf-8 result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface nstr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [1:0] status;

    modport source (output valid, output out_byte, output byte_valid,
                    output string_done, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input string_done, input status, output ready);
endinterface

/* src/name_string_to_utf8_transcoder.sv */
// ----------------------------------------------------------------------------
// name_string_to_utf8_transcoder
// Converts a string given as raw bytes (Latin-1, or big-endian UTF-16 with
// surrogate pairs) into UTF-8, one output byte per transfer, and closes each
// string with a status transfer (0 ok, 1 embedded null, 2 bad or truncated
// surrogate). The front accepts one input byte per cycle whenever the job
// queue has room; the back drives a single registered output byte lane, so
// one character costs one to four output transfers and the end of a string one
// more. That output lane sets the sustained rate whenever characters need
// more output bytes than they took input bytes. The first result passes the
// job queue and the output register before it is offered. Null characters
// give no bytes; after the first error the string's bytes carry no meaning.
// The user must write the source encoding register only while the block is
// idle, through cfg_wr_en/cfg_wr_data; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module name_string_to_utf8_transcoder
    import nstr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2    // jobs between front and back, 2 to 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    nstr_in_if.sink    in_ch,
    nstr_out_if.source out_ch
);

    // front to queue
    nstr_job_t wr_job;
    logic      push;
    logic      full;

    // queue to back
    nstr_job_t head;
    logic      head_valid;
    logic      pop;

    // front: decode state, error tracking, one job per character or string end
    nstr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .full        (full),
        .push        (push),
        .job         (wr_job)
    );

    // queue decouples the byte-per-cycle front from the multi-byte back
    nstr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .wr_job     (wr_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    // back: utf-8 byte sequencer with an output register
    nstr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );

`ifndef SYNTHESIS
    // status transfer carries no byte
    a_status_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_done |-> !out_ch.byte_valid && out_ch.out_byte == 8'h00)
        else $error("status transfer carries a byte");
`endif

endmodule

/* src/nstr_front.sv */
// ----------------------------------------------------------------------------
// nstr_front
// accepts source bytes, pairs utf-16 units, tracks errors, builds jobs
// ----------------------------------------------------------------------------
module nstr_front
    import nstr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    nstr_in_if.sink   in_ch,
    input  logic      full,
    output logic      push,
    output nstr_job_t job
);

    logic       src_utf16_reg;
    logic       hfb_reg, hfb_next;
    logic [7:0] held_reg, held_next;
    logic       hhs_reg, hhs_next;
    logic [9:0] hsb_reg, hsb_next;
    logic       null_reg, null_next;
    logic [1:0] err_reg, err_next;

    logic        accept;
    logic [15:0] unit;
    logic        do_char;
    logic [20:0] ch;
    logic [20:0] pair_cp;

    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && !full;
    assign unit        = {held_reg, in_ch.in_byte};
    assign pair_cp     = 21'h10000 + {1'b0, hsb_reg, unit[9:0]};

    always_comb
    begin
        hfb_next   = hfb_reg;
        held_next  = held_reg;
        hhs_next   = hhs_reg;
        hsb_next   = hsb_reg;
        null_next  = null_reg;
        err_next   = err_reg;
        do_char    = 1'b0;
        ch         = '0;
        job.cp     = '0;
        job.nbytes = 3'd0;
        job.done   = in_ch.in_last;
        job.status = ST_OK;

        if (src_utf16_reg)
        begin
            if (!hfb_reg)
            begin
                // odd final byte is dropped
                if (!in_ch.in_last)
                begin
                    hfb_next  = 1'b1;
                    held_next = in_ch.in_byte;
                end
            end
            else
            begin
                hfb_next  = 1'b0;
                held_next = '0;
                if (err_reg == ST_OK)
                begin
                    if (hhs_reg)
                    begin
                        hhs_next = 1'b0;
                        hsb_next = '0;
                        if (unit inside {[16'hDC00:16'hDFFF]})
                        begin
                            do_char = 1'b1;
                            ch      = pair_cp;
                        end
                        else
                        begin
                            err_next = ST_SURR;
                        end
                    end
                    else if (unit inside {[16'hD800:16'hDBFF]})
                    begin
                        hhs_next = 1'b1;
                        hsb_next = unit[9:0];
                    end
                    else if (unit inside {[16'hDC00:16'hDFFF]})
                    begin
                        err_next = ST_SURR;
                    end
                    else
                    begin
                        do_char = 1'b1;
                        ch      = {5'b0, unit};
                    end
                end
            end
        end
        else if (err_reg == ST_OK)
        begin
            do_char = 1'b1;
            ch      = {13'b0, in_ch.in_byte};
        end

        if (do_char)
        begin
            if (ch == '0)
            begin
                null_next = 1'b1;
            end
            else if (null_reg)
            begin
                err_next = ST_NULL;
            end
            else
            begin
                job.cp = ch;
                if (ch < 21'h80)
                    job.nbytes = 3'd1;
                else if (ch < 21'h800)
                    job.nbytes = 3'd2;
                else if (ch < 21'h10000)
                    job.nbytes = 3'd3;
                else
                    job.nbytes = 3'd4;
            end
        end

        if (in_ch.in_last)
        begin
            // surrogate still pending at end of string
            if (err_next == ST_OK && hhs_next)
                err_next = ST_SURR;
            job.status = err_next;
            hfb_next   = 1'b0;
            held_next  = '0;
            hhs_next   = 1'b0;
            hsb_next   = '0;
            null_next  = 1'b0;
            err_next   = ST_OK;
        end
    end

    assign push = accept && (job.nbytes != 3'd0 || job.done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_utf16_reg <= 1'b0;
            hfb_reg       <= 1'b0;
            held_reg      <= '0;
            hhs_reg       <= 1'b0;
            hsb_reg       <= '0;
            null_reg      <= 1'b0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
                src_utf16_reg <= cfg_wr_data;
            if (accept)
            begin
                hfb_reg  <= hfb_next;
                held_reg <= held_next;
                hhs_reg  <= hhs_next;
                hsb_reg  <= hsb_next;
                null_reg <= null_next;
                err_reg  <= err_next;
            end
        end
    end

endmodule

/* src/nstr_queue.sv */
// ----------------------------------------------------------------------------
// nstr_queue
// short job queue between front and back, flip-flop storage
// ----------------------------------------------------------------------------
module nstr_queue
    import nstr_pkg::*;
#(
    parameter int DEPTH = 2    // 2 to 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  nstr_job_t wr_job,
    input  logic      pop,
    output nstr_job_t head,
    output logic      head_valid,
    output logic      full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    nstr_job_t       entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |=> count_reg == CW'(DEPTH))
        else $error("queue entry lost or invented while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
`endif

endmodule

/* src/nstr_back.sv */
// ----------------------------------------------------------------------------
// nstr_back
// expands a job into utf-8 byte results and the closing status result
// ----------------------------------------------------------------------------
module nstr_back
    import nstr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  nstr_job_t  head,
    input  logic       head_valid,
    output logic       pop,
    nstr_out_if.source out_ch
);

    logic [2:0] idx_reg;
    logic [2:0] total;
    logic       load;
    logic       last_res;
    logic       valid_reg;
    logic [7:0] byte_reg, byte_next;
    logic       bv_reg, bv_next;
    logic       done_reg, done_next;
    logic [1:0] status_reg, status_next;

    function automatic logic [7:0] utf8_byte(logic [20:0] cp, logic [2:0] nb,
                                             logic [2:0] idx);
        logic [7:0] b;
        begin
            b = 8'h00;
            case (nb)
                3'd1: b = cp[7:0];
                3'd2: b = (idx == 3'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                3'd3:
                begin
                    case (idx)
                        3'd0:    b = {4'b1110, cp[15:12]};
                        3'd1:    b = {2'b10, cp[11:6]};
                        default: b = {2'b10, cp[5:0]};
                    endcase
                end
                3'd4:
                begin
                    case (idx)
                        3'd0:    b = {5'b11110, cp[20:18]};
                        3'd1:    b = {2'b10, cp[17:12]};
                        3'd2:    b = {2'b10, cp[11:6]};
                        default: b = {2'b10, cp[5:0]};
                    endcase
                end
                default: b = 8'h00;
            endcase
            return b;
        end
    endfunction

    assign total    = head.nbytes + {2'b0, head.done};
    assign last_res = (idx_reg == total - 3'd1);
    assign load     = head_valid && (!valid_reg || out_ch.ready);
    assign pop      = load && last_res;

    always_comb
    begin
        if (idx_reg < head.nbytes)
        begin
            byte_next   = utf8_byte(head.cp, head.nbytes, idx_reg);
            bv_next     = 1'b1;
            done_next   = 1'b0;
            status_next = ST_OK;
        end
        else
        begin
            byte_next   = 8'h00;
            bv_next     = 1'b0;
            done_next   = 1'b1;
            status_next = head.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg   <= byte_next;
            bv_reg     <= bv_next;
            done_reg   <= done_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= last_res ? 3'd0 : idx_reg + 3'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ch.ready)
                valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.byte_valid  = bv_reg;
    assign out_ch.string_done = done_reg;
    assign out_ch.status      = status_reg;

`ifndef SYNTHESIS
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 3'd0 |-> head_valid && idx_reg < total)
        else $error("partly emitted job left the queue head");
`endif

endmodule

/* bench/utf8_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_checker
// watches the byte and result channels of the transcoder, predicts the utf-8
// bytes and closing status of each string, and compares every result transfer
// ----------------------------------------------------------------------------
module utf8_checker
    import nstr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       string_done,
    input  logic [1:0] status,
    output int         fail_count,
    output int         pending
);

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       string_done;
        logic [1:0] status;
    } utf8_res_t;

    utf8_res_t   expected_utf8[$];

    // shadow of the encoding register and of the per-string state
    logic        utf16_mode;
    logic        pair_pending;
    logic [7:0]  pair_high;
    logic        surr_pending;
    logic [9:0]  surr_bits;
    logic        null_seen;
    logic [1:0]  err_code;

    function automatic void clear_string();
        pair_pending = 1'b0;
        pair_high    = 8'h00;
        surr_pending = 1'b0;
        surr_bits    = 10'd0;
        null_seen    = 1'b0;
        err_code     = ST_OK;
    endfunction

    function automatic void push_utf8(input logic [7:0] b);
        expected_utf8.push_back(utf8_res_t'{b, 1'b1, 1'b0, err_code});
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp == 21'd0)
            null_seen = 1'b1;
        else if (null_seen)
            err_code = ST_NULL;
        else if (cp < 21'h80)
            push_utf8(cp[7:0]);
        else if (cp < 21'h800)
        begin
            push_utf8({3'b110, cp[10:6]});
            push_utf8({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            push_utf8({4'b1110, cp[15:12]});
            push_utf8({2'b10, cp[11:6]});
            push_utf8({2'b10, cp[5:0]});
        end
        else
        begin
            push_utf8({5'b11110, cp[20:18]});
            push_utf8({2'b10, cp[17:12]});
            push_utf8({2'b10, cp[11:6]});
            push_utf8({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void take_code_unit(input logic [15:0] u);
        logic       is_high;
        logic       is_low;
        logic [9:0] saved;
        is_high = (u >= HIGH_SURR_FIRST) && (u <= HIGH_SURR_LAST);
        is_low  = (u >= LOW_SURR_FIRST) && (u <= LOW_SURR_LAST);
        if (surr_pending)
        begin
            saved        = surr_bits;
            surr_pending = 1'b0;
            surr_bits    = 10'd0;
            if (is_low)
                emit_code_point(21'h10000 + {1'b0, saved, u[9:0]});
            else
                err_code = ST_SURR;
        end
        else if (is_high)
        begin
            surr_pending = 1'b1;
            surr_bits    = u[9:0];
        end
        else if (is_low)
            err_code = ST_SURR;
        else
            emit_code_point({5'b0, u});
    endfunction

    // predicts the results caused by one accepted source byte
    function automatic void transcode_byte(input logic [7:0] b, input logic last);
        logic [15:0] code_unit;
        if (utf16_mode)
        begin
            if (!pair_pending)
            begin
                // odd final byte is dropped
                if (!last)
                begin
                    pair_pending = 1'b1;
                    pair_high    = b;
                end
            end
            else
            begin
                code_unit    = {pair_high, b};
                pair_pending = 1'b0;
                pair_high    = 8'h00;
                if (err_code == ST_OK)
                    take_code_unit(code_unit);
            end
        end
        else if (err_code == ST_OK)
            emit_code_point({13'b0, b});
        if (last)
        begin
            // truncated surrogate is checked in either mode
            if (err_code == ST_OK && surr_pending)
                err_code = ST_SURR;
            expected_utf8.push_back(utf8_res_t'{8'h00, 1'b0, 1'b1, err_code});
            clear_string();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        utf8_res_t exp_res;
        if (!rst_n)
        begin
            utf16_mode = 1'b0;
            clear_string();
            expected_utf8.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                transcode_byte(in_byte, in_last);
            if (out_valid && out_ready)
            begin
                if (expected_utf8.size() == 0)
                begin
                    $error("result transfer with nothing expected: out_byte %h status %0d",
                           out_byte, status);
                    fail_count++;
                end
                else
                begin
                    exp_res = expected_utf8.pop_front();
                    if (out_byte !== exp_res.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", exp_res.out_byte, out_byte);
                        fail_count++;
                    end
                    if (byte_valid !== exp_res.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b",
                               exp_res.byte_valid, byte_valid);
                        fail_count++;
                    end
                    if (string_done !== exp_res.string_done)
                    begin
                        $error("string_done: expected %b, got %b",
                               exp_res.string_done, string_done);
                        fail_count++;
                    end
                    if (status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, status);
                        fail_count++;
                    end
                end
            end
            if (cfg_wr_en)
                utf16_mode = cfg_wr_data;
            pending <= expected_utf8.size();
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the name-string transcoder: directed strings in
// both encodings, then random strings under three idle patterns, with a
// checker beside the block predicting and comparing every result transfer
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int QUIET_CYCLES    = 6;     // extra wait at the end of a drain
    localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no transfer at all
    localparam int ITEMS_PER_BLOCK = 14;    // six random blocks, ~100 bytes

    localparam logic MODE_LATIN1 = 1'b0;
    localparam logic MODE_UTF16  = 1'b1;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    int         src_idle   = 0;   // percent of cycles the sender holds back
    int         sink_idle  = 0;   // percent of cycles the receiver stalls
    int         items_sent = 0;
    int         fail_count;
    int         pending;
    logic [7:0] str_bytes[$];     // source string being built or sent

    nstr_in_if  in_if();
    nstr_out_if out_if();

    name_string_to_utf8_transcoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_if),
        .out_ch      (out_if)
    );

    utf8_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_if.valid),
        .in_ready    (in_if.ready),
        .in_byte     (in_if.in_byte),
        .in_last     (in_if.in_last),
        .out_valid   (out_if.valid),
        .out_ready   (out_if.ready),
        .out_byte    (out_if.out_byte),
        .byte_valid  (out_if.byte_valid),
        .string_done (out_if.string_done),
        .status      (out_if.status),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // receiver side: ready drawn fresh every cycle from the current stall rate
    initial
    begin
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_if.ready <= ($urandom_range(0, 99) >= sink_idle);
        end
    end

    // watchdog: ends the run when nothing has been transferred for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb_top failed");
        $finish;
    end

    // one source byte: random hold-off, then hold valid until the transfer
    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        in_if.in_last <= last;
        do
            @(posedge clk);
        while (!in_if.ready);
        items_sent++;
    endtask

    // stop sending and wait until every predicted result has come out,
    // then give the block some extra cycles for work that has no result
    task automatic drain(input int extra);
        in_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    // encoding register write, issued after reset or a drain, once in mid-string
    task automatic write_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // sends str_bytes with last on its final byte; optionally stalls halfway
    // until the block has caught up with everything sent so far
    task automatic send_string(input bit pause_mid);
        for (int i = 0; i < str_bytes.size(); i++)
        begin
            if (pause_mid && i == str_bytes.size() / 2)
                drain(0);
            send_item(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    function automatic void push_unit(input logic [15:0] u);
        str_bytes.push_back(u[15:8]);
        str_bytes.push_back(u[7:0]);
    endfunction

    // latin-1 string: mostly non-null bytes over the full range, now and
    // then a null inside (embedded null) or at the tail (harmless)
    function automatic void build_latin_string();
        int len;
        str_bytes.delete();
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
            str_bytes.push_back(($urandom_range(0, 99) < 8) ? 8'h00
                                                            : 8'($urandom_range(1, 255)));
        if ($urandom_range(0, 3) == 0)
            str_bytes.push_back(8'h00);
    endfunction

    // utf-16 string: well-formed units of every utf-8 length and proper
    // surrogate pairs; about one string in five carries noise or a broken end
    function automatic void build_utf16_string();
        int          units;
        bit          noisy;
        logic [15:0] u;
        logic [9:0]  r;
        str_bytes.delete();
        units = $urandom_range(1, 4);
        noisy = ($urandom_range(0, 99) < 20);
        for (int k = 0; k < units; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: u = 16'($urandom_range(1, 16'h7F));
                3:       u = 16'($urandom_range(16'h80, 16'h7FF));
                4, 5:
                begin
                    u = 16'($urandom_range(16'h800, 16'hFFFF));
                    // move surrogate values out of the way
                    if (u[15:11] == 5'b11011)
                        u[13] = ~u[13];
                end
                6, 7:
                begin
                    r = 10'($urandom);
                    push_unit(16'hD800 | {6'b0, r});
                    r = 10'($urandom);
                    u = 16'hDC00 | {6'b0, r};
                end
                8:       u = 16'h0000;
                default: u = noisy ? 16'($urandom) : 16'h0041;
            endcase
            push_unit(u);
        end
        if (noisy)
        begin
            r = 10'($urandom);
            case ($urandom_range(0, 2))
                0:       str_bytes.push_back(8'($urandom));   // odd final byte
                1:       push_unit(16'hD800 | {6'b0, r});     // truncated pair
                default: push_unit(16'hDC00 | {6'b0, r});     // lone low half
            endcase
        end
    endfunction

    // main stimulus
    initial
    begin
        int  block_start;
        bit  mode;
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= 8'h00;
        in_if.in_last <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // latin-1: ascii top, first high byte, all ones
        write_mode(MODE_LATIN1);
        str_bytes = '{8'h7F, 8'h80, 8'hFF};
        send_string(1'b0);
        // latin-1: null followed by a character
        str_bytes = '{8'h00, 8'h41};
        send_string(1'b0);

        // utf-16: null unit, ascii, two-byte max, smallest pair, odd final byte
        drain(QUIET_CYCLES);
        write_mode(MODE_UTF16);
        str_bytes = '{8'h00, 8'h00, 8'h00, 8'h41, 8'h07, 8'hFF,
                      8'hD8, 8'h00, 8'hDC, 8'h00, 8'h12};
        send_string(1'b0);
        // utf-16: largest bmp unit, largest pair, then a lone low half
        str_bytes = '{8'hFF, 8'hFF, 8'hDB, 8'hFF, 8'hDF, 8'hFF, 8'hDC, 8'h00};
        send_string(1'b0);
        // utf-16: high half followed by an ordinary unit
        str_bytes = '{8'hD8, 8'h00, 8'h00, 8'h41};
        send_string(1'b0);
        // utf-16: high half cut off by the end of the string
        str_bytes = '{8'hDB, 8'hFF};
        send_string(1'b0);

        // encoding switched in mid-string with a high half still pending:
        // the latin-1 byte goes out and the end reports the truncation
        send_item(8'hD8, 1'b0);
        send_item(8'h3F, 1'b0);
        drain(QUIET_CYCLES);
        write_mode(MODE_LATIN1);
        send_item(8'h41, 1'b1);

        // random strings under three idle patterns, both encodings in each
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle  = 31;
                    sink_idle = 79;
                end
                1:
                begin
                    src_idle  = 79;
                    sink_idle = 31;
                end
                default:
                begin
                    src_idle  = 0;
                    sink_idle = 0;
                end
            endcase
            for (int sub = 0; sub < 2; sub++)
            begin
                mode = 1'((ph + sub) % 2);
                drain(QUIET_CYCLES);
                write_mode(mode);
                block_start = items_sent;
                while (items_sent - block_start < ITEMS_PER_BLOCK)
                begin
                    if (mode == MODE_UTF16)
                        build_utf16_string();
                    else
                        build_latin_string();
                    // first string of each phase stalls halfway until drained
                    send_string(sub == 0 && items_sent == block_start);
                end
            end
        end

        // let everything come out, then the verdict
        drain(QUIET_CYCLES);
        if (fail_count == 0 && pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
